@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bpru_pkg.sv @@
`default_nettype none
package bpru_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_LIMIT     = (MAX_DIMENSION < 4096) ? MAX_DIMENSION : 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    // input operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PALETTE = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    // pixel format codes
    localparam logic [2:0] FMT_1BIT  = 3'd0;
    localparam logic [2:0] FMT_4BIT  = 3'd1;
    localparam logic [2:0] FMT_8BIT  = 3'd2;
    localparam logic [2:0] FMT_24BIT = 3'd3;
    localparam logic [2:0] FMT_32BIT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_PALETTE,
        KIND_PIXEL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  pal_idx;
        logic [23:0] pal_rgb;
    } t_entry;

    typedef struct packed {
        logic [2:0]  fmt;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

endpackage
`default_nettype wire

@@ hdl/bpru_front.sv @@
`default_nettype none
module bpru_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic [7:0]    i_palette_index,
    input  wire logic [7:0]    i_palette_red,
    input  wire logic [7:0]    i_palette_green,
    input  wire logic [7:0]    i_palette_blue,
    input  wire logic [2:0]    i_fmt,
    input  wire logic          i_q_full,
    output logic               o_push,
    output bpru_pkg::t_entry   o_entry
);
    import bpru_pkg::*;

    logic keep;

    assign o_ready = !i_q_full;

    // classify the word; unknown ops and bytes of an unknown format are dropped here
    always_comb begin
        keep            = 1'b0;
        o_entry.kind    = KIND_START;
        o_entry.data    = i_data_byte;
        o_entry.pal_idx = i_palette_index;
        o_entry.pal_rgb = {i_palette_red, i_palette_green, i_palette_blue};
        case (i_op)
            OP_START: begin
                keep         = 1'b1;
                o_entry.kind = KIND_START;
            end
            OP_PALETTE: begin
                keep         = 1'b1;
                o_entry.kind = KIND_PALETTE;
            end
            OP_PIXEL: begin
                keep         = (i_fmt <= FMT_32BIT);
                o_entry.kind = KIND_PIXEL;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && !i_q_full && keep;

endmodule
`default_nettype wire

@@ hdl/bpru_queue.sv @@
`default_nettype none
module bpru_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bpru_pkg::t_entry i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output bpru_pkg::t_entry      o_entry,
    input  wire logic             i_pop
);
    import bpru_pkg::*;

    t_entry                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count,  n_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bpru_back.sv @@
`default_nettype none
module bpru_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bpru_pkg::t_cfg   i_cfg,
    input  wire logic             i_q_valid,
    input  wire bpru_pkg::t_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [23:0]           o_pixel_address,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    output logic                  o_last_of_run,
    output logic                  o_image_done
);
    import bpru_pkg::*;

    localparam logic [8:0] PalLimit = 9'(PALETTE_DEPTH);

    // position and gather state
    logic [11:0] r_col,      n_col;
    logic [11:0] r_row,      n_row;
    logic [1:0]  r_phase,    n_phase;
    logic [23:0] r_gath,     n_gath;
    logic [1:0]  r_pad,      n_pad;
    logic        r_finished, n_finished;
    // multi-pixel byte in progress
    logic        r_busy,     n_busy;
    logic [2:0]  r_k,        n_k;
    logic [7:0]  r_data,     n_data;

    // palette store, no reset
    logic [23:0] r_pal_mem [PALETTE_DEPTH];
    logic [23:0] r_rdata;

    // lookup stage
    logic        r_l_valid;
    logic [23:0] r_l_addr;
    logic        r_l_pal;
    logic        r_l_hit;
    logic [23:0] r_l_rgb;
    logic [7:0]  r_l_alpha;
    logic        r_l_last;
    logic        r_l_done;

    // output register
    logic        r_o_valid;
    logic [23:0] r_o_addr;
    logic [23:0] r_o_rgb;
    logic [7:0]  r_o_alpha;
    logic        r_o_last;
    logic        r_o_done;

    logic        out_free, adv, take;
    logic [7:0]  cur_data;
    logic [2:0]  cur_k, last_k;
    logic        emit, px_pal, px_hit, px_final;
    logic [7:0]  px_idx;
    logic [23:0] px_rgb;
    logic [7:0]  px_alpha;
    logic        pal_we;
    logic        row_end, frame_end;
    logic [23:0] row_diff;
    logic [36:0] row_prod;
    logic [23:0] px_addr;
    logic [1:0]  row_pad;
    logic        four;

    // padding bytes after a row: bytes needed to round width*bpp up to 32 bits
    function automatic logic [1:0] pad_bytes(input logic [2:0] fmt, input logic [12:0] w);
        logic [4:0] bits;
        logic [1:0] w3;
        logic [4:0] neg;
        w3 = w[1:0] + {w[0], 1'b0};
        case (fmt)
            FMT_1BIT:  bits = w[4:0];
            FMT_4BIT:  bits = {w[2:0], 2'b00};
            FMT_8BIT:  bits = {w[1:0], 3'b000};
            FMT_24BIT: bits = {w3, 3'b000};
            default:   bits = 5'd0;
        endcase
        neg = 5'd0 - bits;
        return neg[4:3];
    endfunction

    assign out_free = !r_o_valid || i_ready;
    assign adv      = !r_l_valid || out_free;
    assign take     = !r_busy && i_q_valid && adv;
    assign o_q_pop  = take;

    assign cur_data = r_busy ? r_data : i_q_entry.data;
    assign cur_k    = r_busy ? r_k : 3'd0;
    assign four     = (i_cfg.fmt == FMT_32BIT);

    // address and row bookkeeping for the pixel at the current position
    assign row_end   = (({1'b0, r_col} + 13'd1) >= i_cfg.width);
    assign frame_end = row_end && (({1'b0, r_row} + 13'd1) >= i_cfg.height);
    assign row_diff  = 24'(i_cfg.height) - 24'd1 - {12'b0, r_row};
    assign row_prod  = row_diff * i_cfg.width;
    assign px_addr   = row_prod[23:0] + {12'b0, r_col};
    assign row_pad   = pad_bytes(i_cfg.fmt, i_cfg.width);

    always_comb begin
        case (i_cfg.fmt)
            FMT_1BIT: px_idx = {7'b0, cur_data[3'd7 - cur_k]};
            FMT_4BIT: px_idx = cur_k[0] ? {4'b0, cur_data[3:0]} : {4'b0, cur_data[7:4]};
            default:  px_idx = cur_data;
        endcase
        case (i_cfg.fmt)
            FMT_1BIT: last_k = 3'd7;
            FMT_4BIT: last_k = 3'd1;
            default:  last_k = 3'd0;
        endcase
    end

    assign px_hit   = ({1'b0, px_idx} < PalLimit);
    assign px_final = row_end || (cur_k == last_k);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_phase    = r_phase;
        n_gath     = r_gath;
        n_pad      = r_pad;
        n_finished = r_finished;
        n_busy     = r_busy;
        n_k        = r_k;
        n_data     = r_data;
        emit       = 1'b0;
        px_pal     = 1'b1;
        px_rgb     = 24'd0;
        px_alpha   = 8'hff;
        pal_we     = 1'b0;

        if (r_busy) begin
            emit = adv;
        end else if (take) begin
            case (i_q_entry.kind)
                KIND_START: begin
                    n_col      = '0;
                    n_row      = '0;
                    n_phase    = '0;
                    n_gath     = '0;
                    n_pad      = '0;
                    n_finished = 1'b0;
                end
                KIND_PALETTE: begin
                    pal_we = ({1'b0, i_q_entry.pal_idx} < PalLimit);
                end
                KIND_PIXEL: begin
                    if (r_finished) begin
                        n_finished = 1'b1;
                    end else if (r_pad != 2'd0) begin
                        n_pad = r_pad - 2'd1;
                    end else if (i_cfg.fmt <= FMT_8BIT) begin
                        emit = 1'b1;
                    end else begin
                        px_pal = 1'b0;
                        if (r_phase == 2'd0) begin
                            n_gath  = {16'b0, cur_data};
                            n_phase = 2'd1;
                        end else if (r_phase == 2'd1) begin
                            n_gath  = {8'b0, cur_data, r_gath[7:0]};
                            n_phase = 2'd2;
                        end else if (r_phase == 2'd2 && four) begin
                            n_gath  = {cur_data, r_gath[15:0]};
                            n_phase = 2'd3;
                        end else begin
                            emit     = 1'b1;
                            px_rgb   = four ? r_gath : {cur_data, r_gath[15:0]};
                            px_alpha = four ? cur_data : 8'hff;
                            n_gath   = '0;
                            n_phase  = '0;
                        end
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end

        if (emit) begin
            if (frame_end) begin
                n_finished = 1'b1;
                n_col      = '0;
                n_pad      = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + 12'd1;
                n_pad = row_pad;
            end else begin
                n_col = r_col + 12'd1;
            end
            n_busy = !px_final;
            n_k    = cur_k + 3'd1;
            n_data = cur_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= '0;
            r_gath     <= '0;
            r_pad      <= '0;
            r_finished <= 1'b0;
            r_busy     <= 1'b0;
            r_k        <= '0;
            r_l_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_phase    <= n_phase;
            r_gath     <= n_gath;
            r_pad      <= n_pad;
            r_finished <= n_finished;
            r_busy     <= n_busy;
            r_k        <= n_k;
            if (adv) begin
                r_l_valid <= emit;
            end
            if (out_free) begin
                r_o_valid <= r_l_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (adv && emit) begin
            r_l_addr  <= px_addr;
            r_l_pal   <= px_pal;
            r_l_hit   <= px_hit;
            r_l_rgb   <= px_rgb;
            r_l_alpha <= px_alpha;
            r_l_last  <= px_final;
            r_l_done  <= frame_end;
        end
        if (out_free && r_l_valid) begin
            r_o_addr  <= r_l_addr;
            r_o_rgb   <= r_l_pal ? (r_l_hit ? r_rdata : 24'd0) : r_l_rgb;
            r_o_alpha <= r_l_alpha;
            r_o_last  <= r_l_last;
            r_o_done  <= r_l_done;
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[i_q_entry.pal_idx[PAL_AW-1:0]] <= i_q_entry.pal_rgb;
        end
        if (emit && px_pal) begin
            r_rdata <= r_pal_mem[px_idx[PAL_AW-1:0]];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pixel_address = r_o_addr;
    assign o_red           = r_o_rgb[23:16];
    assign o_green         = r_o_rgb[15:8];
    assign o_blue          = r_o_rgb[7:0];
    assign o_alpha         = r_o_alpha;
    assign o_last_of_run   = r_o_last;
    assign o_image_done    = r_o_done;

endmodule
`default_nettype wire

@@ hdl/bmp_pixel_row_unpacker.sv @@
// bitmap pixel row unpacker. words on the input channel are a start-of-image marker
// (clears position, keeps palette), a palette entry write, or one byte of the bitmap
// pixel array. bytes are unpacked as 1-bit (msb first), 4-bit (high nibble first) or
// 8-bit palette indices, or gathered as bgr / bgra; every pixel leaves with its buffer
// address (height-1-row)*width+column, rows flipped bottom-up, plus a last-of-byte and
// an end-of-image flag. row padding bytes are swallowed, bytes after the image are
// dropped until the next start. a front end takes words into a 4-word queue; the back
// end sequencer drains it and, while the output is not stalled, emits one pixel per
// clock through a palette lookup stage and an output register. a 1-bit byte gives up
// to 8 pixels, a 4-bit byte 2, all emitted before the next word is taken. the palette
// memory holds garbage until written; configuration must be written only while the
// block holds no work, which the block does not enforce; o_cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"
module bmp_pixel_row_unpacker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    // input words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_palette_index,
    input  wire logic [7:0]  i_palette_red,
    input  wire logic [7:0]  i_palette_green,
    input  wire logic [7:0]  i_palette_blue,
    // output pixels
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_pixel_address,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_last_of_run,
    output logic             o_image_done
);
    import bpru_pkg::*;

    localparam logic [12:0] DimLimit = 13'(DIM_LIMIT);

    // configuration registers, dimensions stored already clamped
    logic [2:0]  r_fmt;
    logic [12:0] r_width;
    logic [12:0] r_height;
    t_cfg        cfg;

    // front to queue
    logic        w_push;
    t_entry      w_push_entry;
    logic        w_q_full;
    // queue to back
    logic        w_q_valid;
    t_entry      w_q_entry;
    logic        w_q_pop;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0) begin
            return 13'd1;
        end else if (v > DimLimit) begin
            return DimLimit;
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_8BIT;
            r_width  <= 13'd1;
            r_height <= 13'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT: r_fmt    <= i_cfg_data[2:0];
                CFG_WIDTH:  r_width  <= clamp_dim(i_cfg_data);
                CFG_HEIGHT: r_height <= clamp_dim(i_cfg_data);
                default:    r_fmt    <= r_fmt;
            endcase
        end
    end

    assign cfg.fmt    = r_fmt;
    assign cfg.width  = r_width;
    assign cfg.height = r_height;

    // front: accept and classify
    bpru_front u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .i_fmt           (r_fmt),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    // decoupling queue
    bpru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_q_pop)
    );

    // back: sequencer, palette lookup, output register
    bpru_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (w_q_valid),
        .i_q_entry       (w_q_entry),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_address (o_pixel_address),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_last_of_run   (o_last_of_run),
        .o_image_done    (o_image_done)
    );

    // the last pixel of an image always ends its byte's run
    `ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, o_valid && o_image_done, o_last_of_run, "image end without last of run")
    // a full queue is never empty
    `ASSERT_IMPLY(a_full_has_work, i_clk, i_rst_n, !o_ready, w_q_valid, "queue full but empty")
    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid, "output valid after reset")

endmodule
`default_nettype wire

@@ tb/bmp_pixel_row_unpacker_checker.sv @@
module bmp_pixel_row_unpacker_checker
    import bpru_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_palette_index,
    input  wire logic [7:0]  i_palette_red,
    input  wire logic [7:0]  i_palette_green,
    input  wire logic [7:0]  i_palette_blue,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_pixel_address,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_alpha,
    input  wire logic        i_last_of_run,
    input  wire logic        i_image_done,
    output int unsigned      o_pending,
    output int unsigned      o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
        logic        done;
    } t_pixel;

    t_pixel      pixels_due[$];
    logic [2:0]  cur_fmt    = FMT_8BIT;
    logic [12:0] cur_width  = 13'd1;
    logic [12:0] cur_height = 13'd1;
    logic [23:0] palette [PALETTE_DEPTH];
    logic [11:0] col        = '0;
    logic [11:0] row        = '0;
    logic [1:0]  phase      = '0;
    logic [1:0]  pad_left   = '0;
    logic [23:0] gathered   = '0;
    logic        finished   = 1'b0;
    int unsigned fails      = 0;

    // zero acts as one, large values stop at the counter range
    function automatic int unsigned clamp_dim(logic [12:0] v);
        if (v == 0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return v;
    endfunction

    function automatic logic [23:0] palette_rgb(int unsigned idx);
        if (idx >= PALETTE_DEPTH) return 24'h0;
        return palette[idx];
    endfunction

    task automatic emit_pixel(input logic [23:0] rgb, input logic [7:0] alpha,
                              input int unsigned w, input int unsigned h,
                              input int unsigned bpp, output bit row_end);
        int unsigned r;
        int unsigned c;
        int unsigned addr;
        int unsigned pad_bytes;
        bit done;
        t_pixel p;
        r = row;
        c = col;
        addr = (h - 1 - r) * w + c;
        row_end = (c + 1 >= w);
        done = row_end && (r + 1 >= h);
        p.addr  = addr[23:0];
        p.red   = rgb[23:16];
        p.green = rgb[15:8];
        p.blue  = rgb[7:0];
        p.alpha = alpha;
        p.last  = 1'b0;
        p.done  = done;
        pixels_due.push_back(p);
        if (done) begin
            finished = 1'b1;
            col = '0;
            pad_left = '0;
        end else if (row_end) begin
            col = '0;
            row = row + 12'd1;
            pad_bytes = ((32 - w * bpp) & 'h1f) >> 3;
            pad_left = pad_bytes[1:0];
        end else begin
            col = col + 12'd1;
        end
    endtask

    task automatic predict_word();
        int unsigned w;
        int unsigned h;
        int unsigned before_count;
        bit stop;
        bit four;
        logic [7:0] b;
        t_pixel p;
        w = clamp_dim(cur_width);
        h = clamp_dim(cur_height);
        b = i_data_byte;
        before_count = pixels_due.size();
        case (i_op)
            OP_START: begin
                col = '0;
                row = '0;
                phase = '0;
                gathered = '0;
                pad_left = '0;
                finished = 1'b0;
                return;
            end
            OP_PALETTE: begin
                palette[i_palette_index] = {i_palette_red, i_palette_green, i_palette_blue};
                return;
            end
            OP_PIXEL: ;
            default: return;
        endcase
        if (cur_fmt > FMT_32BIT || finished) return;
        // row padding is swallowed
        if (pad_left != 0) begin
            pad_left = pad_left - 2'd1;
            return;
        end
        case (cur_fmt)
            FMT_1BIT: begin
                for (int k = 7; k >= 0; k--) begin
                    emit_pixel(palette_rgb(b[k]), 8'hff, w, h, 1, stop);
                    if (stop) break;
                end
            end
            FMT_4BIT: begin
                emit_pixel(palette_rgb(b[7:4]), 8'hff, w, h, 4, stop);
                if (!stop) emit_pixel(palette_rgb(b[3:0]), 8'hff, w, h, 4, stop);
            end
            FMT_8BIT: emit_pixel(palette_rgb(b), 8'hff, w, h, 8, stop);
            default: begin
                four = (cur_fmt == FMT_32BIT);
                if (phase == 2'd0) begin
                    gathered = {16'h0, b};
                    phase = 2'd1;
                end else if (phase == 2'd1) begin
                    gathered = {8'h0, b, gathered[7:0]};
                    phase = 2'd2;
                end else if (phase == 2'd2 && four) begin
                    gathered = {b, gathered[15:0]};
                    phase = 2'd3;
                end else begin
                    // phase three in 24-bit mode takes this byte as red
                    if (four) emit_pixel(gathered, b, w, h, 32, stop);
                    else emit_pixel({b, gathered[15:0]}, 8'hff, w, h, 24, stop);
                    phase = '0;
                    gathered = '0;
                end
            end
        endcase
        if (pixels_due.size() > before_count) begin
            p = pixels_due.pop_back();
            p.last = 1'b1;
            pixels_due.push_back(p);
        end
    endtask

    function automatic int unsigned mismatch(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_pixel();
        t_pixel want;
        if (pixels_due.size() == 0) begin
            $error("pixel at address 0x%0h with no pixel predicted", i_pixel_address);
            fails++;
            return;
        end
        want = pixels_due.pop_front();
        fails += mismatch("pixel_address", want.addr, i_pixel_address);
        fails += mismatch("red", want.red, i_red);
        fails += mismatch("green", want.green, i_green);
        fails += mismatch("blue", want.blue, i_blue);
        fails += mismatch("alpha", want.alpha, i_alpha);
        fails += mismatch("last_of_run", want.last, i_last_of_run);
        fails += mismatch("image_done", want.done, i_image_done);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_fmt = FMT_8BIT;
            cur_width = 13'd1;
            cur_height = 13'd1;
            col = '0;
            row = '0;
            phase = '0;
            pad_left = '0;
            gathered = '0;
            finished = 1'b0;
            pixels_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORMAT: cur_fmt = i_cfg_data[2:0];
                    CFG_WIDTH:  cur_width = i_cfg_data;
                    CFG_HEIGHT: cur_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_word();
            if (i_out_valid && i_out_ready) check_pixel();
        end
        o_pending <= pixels_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/bmp_pixel_row_unpacker_test.sv @@
module bmp_pixel_row_unpacker_test;
    import bpru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // op code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RANDOM_WORDS = 370;
    localparam int unsigned PHASE_CAP = 64;
    localparam int unsigned DRAIN_CYCLES = 24;
    // slowest run stays well under this limit
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_FORMAT;
    logic [12:0] i_cfg_data      = '0;
    logic        i_valid         = 1'b0;
    logic [1:0]  i_op            = OP_START;
    logic [7:0]  i_data_byte     = '0;
    logic [7:0]  i_palette_index = '0;
    logic [7:0]  i_palette_red   = '0;
    logic [7:0]  i_palette_green = '0;
    logic [7:0]  i_palette_blue  = '0;
    logic        i_ready         = 1'b0;

    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [23:0] o_pixel_address;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_last_of_run;
    logic        o_image_done;

    int unsigned pending;
    int unsigned fail_count;

    // stimulus-side copy of the configuration, used to shape the bytes
    logic [2:0]  fmt_now    = FMT_8BIT;
    logic [12:0] width_now  = 13'd1;
    logic [12:0] height_now = 13'd1;

    // palette entries written so far; unwritten entries are never looked up
    bit          pal_written [PALETTE_DEPTH];
    logic [7:0]  written_list[$];

    int unsigned words_sent     = 0;
    int unsigned directed_words = 0;
    int unsigned phase_no       = 0;
    int unsigned cycle_count    = 0;
    bit          steady         = 1'b0;

    // output side stall state
    int unsigned sink_stall = 0;
    int unsigned sink_calm  = 0;
    int unsigned sink_roll;

    bmp_pixel_row_unpacker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_address (o_pixel_address),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_last_of_run   (o_last_of_run),
        .o_image_done    (o_image_done)
    );

    // predicts every pixel and compares what leaves the block
    bmp_pixel_row_unpacker_checker pixel_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_pixel_address (o_pixel_address),
        .i_red           (o_red),
        .i_green         (o_green),
        .i_blue          (o_blue),
        .i_alpha         (o_alpha),
        .i_last_of_run   (o_last_of_run),
        .i_image_done    (o_image_done),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bmp_pixel_row_unpacker verification failed");
            $finish;
        end
    end

    // output back-pressure: mostly short stalls, a few long ones, calm stretches
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (sink_calm > 0) begin
                sink_calm--;
            end else begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll < 2) sink_calm = $urandom_range(50, 200);
                else if (sink_roll < 25) sink_stall = $urandom_range(1, 3);
                else if (sink_roll < 28) sink_stall = $urandom_range(8, 40);
            end
        end
    end

    // gap after a word on the input side
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one word on the input channel; valid stays up when no gap follows
    task automatic send_word(input logic [1:0] op, input logic [7:0] data,
                             input logic [7:0] pidx, input logic [7:0] pr,
                             input logic [7:0] pg, input logic [7:0] pb);
        int unsigned gap;
        i_valid <= 1'b1;
        i_op <= op;
        i_data_byte <= data;
        i_palette_index <= pidx;
        i_palette_red <= pr;
        i_palette_green <= pg;
        i_palette_blue <= pb;
        do @(posedge i_clk); while (!o_ready);
        if (op != OP_UNUSED) words_sent++;
        gap = idle_cycles();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(input logic [7:0] data);
        send_word(OP_PIXEL, data, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_start();
        send_word(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_unused();
        send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
        send_word(OP_PALETTE, 8'($urandom_range(0, 255)), idx, rgb[23:16], rgb[15:8],
                  rgb[7:0]);
        if (!pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FORMAT: fmt_now = value[2:0];
            CFG_WIDTH:  width_now = value;
            CFG_HEIGHT: height_now = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [2:0] fmt, input logic [12:0] w, input logic [12:0] h);
        write_reg(CFG_FORMAT, {10'h0, fmt});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // input idle, every pixel out, then a pause for words that make no pixel
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // data byte whose palette lookups only hit written entries
    function automatic logic [7:0] pixel_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        int unsigned k;
        case (fmt_now)
            FMT_4BIT: begin
                do hi = 4'($urandom_range(0, 15)); while (!pal_written[hi]);
                do lo = 4'($urandom_range(0, 15)); while (!pal_written[lo]);
                return {hi, lo};
            end
            FMT_8BIT: begin
                k = $urandom_range(0, 255);
                if (!pal_written[k]) k = written_list[$urandom_range(0, written_list.size() - 1)];
                return k[7:0];
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // bytes of a whole image at the current settings, padding included
    function automatic int unsigned frame_bytes();
        int unsigned wc;
        int unsigned hc;
        int unsigned row_bytes;
        wc = (width_now == 0) ? 1 : ((width_now > DIM_LIMIT) ? DIM_LIMIT : width_now);
        hc = (height_now == 0) ? 1 : ((height_now > DIM_LIMIT) ? DIM_LIMIT : height_now);
        case (fmt_now)
            FMT_1BIT:  row_bytes = (wc + 7) / 8;
            FMT_4BIT:  row_bytes = (wc + 1) / 2;
            FMT_8BIT:  row_bytes = wc;
            FMT_24BIT: row_bytes = 3 * wc;
            FMT_32BIT: row_bytes = 4 * wc;
            default:   return 8;
        endcase
        row_bytes += (4 - row_bytes % 4) % 4;
        return row_bytes * hc;
    endfunction

    task automatic random_config();
        int unsigned roll;
        if ($urandom_range(0, 9) < 7) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) write_reg(CFG_FORMAT, {10'h0, FMT_32BIT + 3'($urandom_range(1, 3))});
            else write_reg(CFG_FORMAT, 13'($urandom_range(FMT_1BIT, FMT_32BIT)));
        end
        if ($urandom_range(0, 9) < 7) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) write_reg(CFG_WIDTH, 13'($urandom_range(1, 12)));
            else if (roll < 90) write_reg(CFG_WIDTH, 13'($urandom_range(13, 64)));
            else if (roll < 93) write_reg(CFG_WIDTH, 13'd0);
            else if (roll < 96) write_reg(CFG_WIDTH, 13'd4096);
            else write_reg(CFG_WIDTH, 13'($urandom_range(0, 8191)));
        end
        if ($urandom_range(0, 9) < 7) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) write_reg(CFG_HEIGHT, 13'($urandom_range(1, 4)));
            else if (roll < 92) write_reg(CFG_HEIGHT, 13'($urandom_range(5, 16)));
            else if (roll < 95) write_reg(CFG_HEIGHT, 13'd0);
            else if (roll < 98) write_reg(CFG_HEIGHT, 13'd4096);
            else write_reg(CFG_HEIGHT, 13'd8191);
        end
    endtask

    // one phase: settings, mostly a well-formed image, some noise
    task automatic random_phase();
        int unsigned count;
        int unsigned roll;
        logic [7:0] idx;
        case (phase_no)
            0: set_config(FMT_8BIT, 13'd4096, 13'd4096);   // top address bits
            1: set_config(FMT_1BIT, 13'd1, 13'd4096);      // one pixel per row, full padding
            2: set_config(FMT_32BIT, 13'd0, 13'd0);        // zero dimensions act as one
            3: set_config(FMT_32BIT + 3'd3, 13'd8191, 13'd8191); // unknown format drops bytes
            default: random_config();
        endcase
        phase_no++;
        steady = ($urandom_range(0, 3) == 0);
        // without a start the old position carries over into the new settings
        if (phase_no <= 4 || $urandom_range(0, 9) < 7) send_start();
        count = frame_bytes();
        if (count > PHASE_CAP) count = PHASE_CAP;
        count += $urandom_range(0, 2);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                idx = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 15))
                                                 : 8'($urandom_range(0, 255));
                send_palette(idx, 24'($urandom_range(0, 24'hffffff)));
            end else if (roll < 10) begin
                send_unused();
            end else if (roll < 12) begin
                send_start();
            end else begin
                send_pixel(pixel_byte());
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // palette extremes; entries 0 and 1 serve every 1-bit byte
        send_palette(8'd0, 24'h000000);
        send_palette(8'd1, 24'hffffff);
        send_palette(8'd15, 24'h123456);
        send_palette(8'd255, 24'ha55ac3);

        // reset settings: 8-bit, one pixel image, then a byte past the end
        send_start();
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_unused();
        wait_drained();

        // 1-bit, 3 wide: rest of the byte dropped, three padding words
        set_config(FMT_1BIT, 13'd3, 13'd2);
        send_start();
        send_pixel(8'ha5);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h5a);
        send_pixel(8'h5f);
        wait_drained();

        // 4-bit, high nibble first, image ends inside a byte
        set_config(FMT_4BIT, 13'd3, 13'd1);
        send_start();
        send_pixel(8'hf1);
        send_pixel(8'h0f);
        wait_drained();

        // 32-bit gathered to phase three, then switched to 24-bit: byte taken as red
        set_config(FMT_32BIT, 13'd2, 13'd1);
        send_start();
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_pixel(8'h80);
        wait_drained();
        write_reg(CFG_FORMAT, {10'h0, FMT_24BIT});
        send_pixel(8'h7f);
        wait_drained();

        // plain 24-bit pixel
        set_config(FMT_24BIT, 13'd1, 13'd1);
        send_start();
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'hff);
        wait_drained();

        directed_words = words_sent;
        while (words_sent < directed_words + RANDOM_WORDS) random_phase();

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("bmp_pixel_row_unpacker verification clean");
        end else begin
            $display("bmp_pixel_row_unpacker verification failed");
        end
        $finish;
    end

endmodule
